// File: sv/cti_pkg.sv
package cti_pkg;

    // default sample width, Q16.16
    localparam int CTI_SAMPLE_WIDTH = 32;

    // running integral width, signed Q32.32
    localparam int CTI_INT_WIDTH = 64;

    // control from the sequencer to the shift-add multiplier
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    // status from the multiplier back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// File: sv/cti_mul.sv
module cti_mul #(
    parameter int SAMPLE_WIDTH = cti_pkg::CTI_SAMPLE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cti_pkg::mul_ctl_t           ctl,
    input  logic [SAMPLE_WIDTH:0]       mcand,
    input  logic [SAMPLE_WIDTH-1:0]     mplier,
    output cti_pkg::mul_stat_t          stat,
    output logic [2*SAMPLE_WIDTH:0]     product
);
    import cti_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(SW);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SW:0]       hi_reg;
    logic [SW-1:0]     lo_reg;
    logic [SW:0]       mcand_reg;
    logic [SW+1:0]     step_next;

    // one partial product per cycle, shared adder
    assign step_next = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctl.start) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= CW'(SW - 1);
            hi_reg    <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
        end else if (busy_reg) begin
            hi_reg  <= step_next[SW+1:1];
            lo_reg  <= {step_next[0], lo_reg[SW-1:1]};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // done marks the cycle of the last step
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign product   = {hi_reg, lo_reg};

endmodule

// File: sv/cumulative_trapezoid_integrator.sv
// Cumulative trapezoidal integrator over a stream of (x, y) samples.
// Input channel s_*: one transfer per sample, x and y in tdata, the null
// flags in tuser, tlast marks the last sample of a series.
// Result channel m_*: exactly one transfer per input sample, carrying the
// sample's x and Q32.32 running integral, zero if dropped, and the flags.
// A dropped sample or the first clean sample of a series goes from its
// transfer straight to the final step and on into the output register.
// Any later clean sample runs the segment area through a shift-add
// multiplier that takes one multiplier bit per cycle, then through the
// sign step and the accumulate step to the final step. s_tready is low
// from the transfer until the result is in the output register; one
// sample is in work at a time, so a new sample enters only once the
// previous result is loaded. The output register lets the next sample enter
// while a result waits; if the receiver stalls, the block holds its
// finished result in the final step until the output register frees up.
// Reset (aresetn low, synchronous) clears the series state, drops any
// sample in work and empties the output register.
module cumulative_trapezoid_integrator #(
    parameter int SAMPLE_WIDTH = cti_pkg::CTI_SAMPLE_WIDTH
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // x_in, y_in
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // x_is_null, y_is_null
    input  logic [1:0]                                s_tuser,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // x_out, integral_out
    output logic [((SAMPLE_WIDTH+64+7)/8)*8-1:0]      m_tdata,
    // point_valid, too_short, saturated
    output logic [2:0]                                m_tuser,
    output logic                                      m_tlast
);
    import cti_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = CTI_INT_WIDTH;
    localparam int OW = ((SW + 64 + 7) / 8) * 8;
    localparam int PW = 2 * SW + 2;
    localparam int AW = ((PW > IW) ? PW : IW) + 1;
    localparam logic [1:0] SEEN_ZERO = 2'd0;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_NEG,
        S_ACC,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [SW-1:0]     x_reg;
    logic [SW-1:0]     y_reg;
    logic              clean_reg;
    logic              end_reg;
    logic [SW-1:0]     prev_x_reg;
    logic [SW-1:0]     prev_y_reg;
    logic [IW-1:0]     integ_reg;
    logic [1:0]        seen_reg;
    logic              clip_reg;
    logic              neg_reg;
    logic [PW-1:0]     sprod_reg;
    logic [IW-1:0]     accres_reg;
    logic              clipnew_reg;
    logic              m_tvalid_reg;
    logic [OW-1:0]     m_tdata_reg;
    logic [2:0]        m_tuser_reg;
    logic              m_tlast_reg;

    logic [SW:0]       sum_next;
    logic [SW:0]       mag_next;
    logic [SW:0]       diff_next;
    logic [SW:0]       dabs_next;
    logic [PW-1:0]     half_next;
    logic [AW-1:0]     wide_next;
    logic              fits_next;
    logic [1:0]        seen_next;
    logic [IW-1:0]     integ_next;
    logic              clip_next;
    logic              out_free;

    mul_ctl_t          mul_ctl;
    mul_stat_t         mul_stat;
    logic [2*SW:0]     product;

    // segment operands: |y_prev + y| and |x - x_prev|
    always_comb begin
        sum_next  = {prev_y_reg[SW-1], prev_y_reg} + {y_reg[SW-1], y_reg};
        mag_next  = sum_next[SW] ? (~sum_next + 1'b1) : sum_next;
        diff_next = {x_reg[SW-1], x_reg} - {prev_x_reg[SW-1], prev_x_reg};
        dabs_next = diff_next[SW] ? (~diff_next + 1'b1) : diff_next;
    end

    assign mul_ctl.start = (state_reg == S_PREP);

    cti_mul #(
        .SAMPLE_WIDTH (SW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .mcand   (mag_next),
        .mplier  (dabs_next[SW-1:0]),
        .stat    (mul_stat),
        .product (product)
    );

    // halve toward minus infinity, add, clip to the 64-bit range
    always_comb begin
        half_next = {sprod_reg[PW-1], sprod_reg[PW-1:1]};
        wide_next = {{(AW-PW){half_next[PW-1]}}, half_next}
                  + {{(AW-IW){integ_reg[IW-1]}}, integ_reg};
        fits_next = (&wide_next[AW-1:IW-1]) || !(|wide_next[AW-1:IW-1]);
    end

    // series state after the sample in work
    always_comb begin
        seen_next  = seen_reg;
        integ_next = integ_reg;
        clip_next  = clip_reg;
        if (clean_reg) begin
            seen_next = (seen_reg == SEEN_TWO) ? SEEN_TWO : seen_reg + 1'b1;
            if (seen_reg == SEEN_ZERO) begin
                integ_next = '0;
            end else begin
                integ_next = accres_reg;
                clip_next  = clip_reg | clipnew_reg;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer, series state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            integ_reg    <= '0;
            seen_reg     <= SEEN_ZERO;
            clip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the final step reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= s_tdata[SW-1:0];
                        y_reg     <= s_tdata[2*SW-1:SW];
                        clean_reg <= !s_tuser[0] && !s_tuser[1];
                        end_reg   <= s_tlast;
                        if (!s_tuser[0] && !s_tuser[1] && (seen_reg != SEEN_ZERO)) begin
                            state_reg <= S_PREP;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_PREP: begin
                    neg_reg   <= sum_next[SW];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (mul_stat.done) begin
                        state_reg <= S_NEG;
                    end
                end
                S_NEG: begin
                    sprod_reg <= neg_reg ? (~{1'b0, product} + 1'b1) : {1'b0, product};
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (fits_next) begin
                        accres_reg  <= wide_next[IW-1:0];
                        clipnew_reg <= 1'b0;
                    end else begin
                        accres_reg  <= wide_next[AW-1] ? INT_MIN : INT_MAX;
                        clipnew_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= clean_reg ? OW'({integ_next, x_reg}) : '0;
                        m_tuser_reg  <= {clip_next, end_reg && (seen_next != SEEN_TWO),
                                         clean_reg};
                        m_tlast_reg  <= end_reg;
                        if (end_reg) begin
                            prev_x_reg <= '0;
                            prev_y_reg <= '0;
                            integ_reg  <= '0;
                            seen_reg   <= SEEN_ZERO;
                            clip_reg   <= 1'b0;
                        end else begin
                            if (clean_reg) begin
                                prev_x_reg <= x_reg;
                                prev_y_reg <= y_reg;
                            end
                            integ_reg <= integ_next;
                            seen_reg  <= seen_next;
                            clip_reg  <= clip_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: sv/cti_checker.sv
module cti_checker #(
    parameter int SAMPLE_WIDTH = cti_pkg::CTI_SAMPLE_WIDTH
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    input  logic                                      s_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    input  logic [1:0]                                s_tuser,
    input  logic                                      s_tlast,
    input  logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic [((SAMPLE_WIDTH+64+7)/8)*8-1:0]      m_tdata,
    input  logic [2:0]                                m_tuser,
    input  logic                                      m_tlast
);
    import cti_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one sample in work: no transfer right after a transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in work");

    // dropped samples carry a zero payload
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("dropped sample with nonzero payload");

    // the short-series flag only comes with the series end
    a_short_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("too_short flagged before series end");

endmodule

bind cumulative_trapezoid_integrator cti_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cti_checker (.*);

// File: tb/cumulative_trapezoid_integrator_tb.sv
module cumulative_trapezoid_integrator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = cti_pkg::CTI_SAMPLE_WIDTH;
    localparam int IW = cti_pkg::CTI_INT_WIDTH;
    localparam int DW_IN = ((2*SW+7)/8)*8;
    localparam int DW_OUT = ((SW+64+7)/8)*8;

    localparam int RANDOM_ITEMS = 1900;
    localparam int PAUSE_AT = 1000;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 2*SW + 10;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_ONE = 1 << 16;

    typedef struct packed {
        logic [SW-1:0] y;
        logic [SW-1:0] x;
        logic          x_null;
        logic          y_null;
        logic          last;
    } sample_t;

    typedef struct packed {
        logic          point_valid;
        logic [SW-1:0] x;
        logic [IW-1:0] integral;
        logic          last;
        logic          too_short;
        logic          saturated;
    } point_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DW_IN-1:0]  s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DW_OUT-1:0] m_tdata;
    logic [2:0]        m_tuser;
    logic              m_tlast;

    // stimulus and expected results
    sample_t sample_queue[$];
    point_t  expected_points[$];
    sample_t current_sample;

    // predictor copy of the series state
    logic signed [SW-1:0] last_x = '0;
    logic signed [SW-1:0] last_y = '0;
    logic signed [IW-1:0] area_sum = '0;
    int                   clean_count = 0;
    logic                 clip_flag = 1'b0;

    int errors = 0;
    int sent_count = 0;
    int results_seen = 0;
    int send_gap = 0;
    int ready_wait = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int series_seen = 0;
    int clean_seen = 0;
    int clipped_seen = 0;
    int short_seen = 0;

    cumulative_trapezoid_integrator #(
        .SAMPLE_WIDTH(SW)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // clock, period 2 ns
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // next point of the running integral, updates the series state
    function automatic point_t integrate_sample(sample_t s);
        point_t              r;
        logic signed [71:0]  ya, yb, xa, xb, ysum, dx, area, total;
        r = '0;
        if (!s.x_null && !s.y_null) begin
            if (clean_count == 0) begin
                area_sum = '0;
            end else begin
                ya = $signed(s.y);
                yb = last_y;
                xa = $signed(s.x);
                xb = last_x;
                ysum = ya + yb;
                dx = xa - xb;
                if (dx < 0)
                    dx = -dx;
                // doubled area halved, rounding toward minus infinity
                area = (ysum * dx) >>> 1;
                total = area + area_sum;
                if (total[71:IW-1] != {(73-IW){total[IW-1]}}) begin
                    clip_flag = 1'b1;
                    area_sum = total[71] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
                end else begin
                    area_sum = total[IW-1:0];
                end
            end
            last_x = s.x;
            last_y = s.y;
            if (clean_count < 2)
                clean_count++;
            r.point_valid = 1'b1;
            r.x = s.x;
            r.integral = area_sum;
        end
        r.last = s.last;
        r.too_short = s.last && (clean_count < 2);
        r.saturated = clip_flag;
        // series end returns to the reset state
        if (s.last) begin
            last_x = '0;
            last_y = '0;
            area_sum = '0;
            clean_count = 0;
            clip_flag = 1'b0;
        end
        return r;
    endfunction

    task automatic add_sample(input logic [SW-1:0] x, input logic [SW-1:0] y,
                              input logic xn, input logic yn, input logic last);
        sample_t s;
        s.x = x;
        s.y = y;
        s.x_null = xn;
        s.y_null = yn;
        s.last = last;
        sample_queue.push_back(s);
    endtask

    function automatic logic [SW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return '1;
            default: return S_ONE;
        endcase
    endfunction

    // sample driver: one transfer per queued sample, random gaps
    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_points.push_back(integrate_sample(current_sample));
                sent_count++;
                next_valid = 1'b0;
                if (sent_count % 150 == 0)
                    send_idle_on = ($urandom_range(0, 2) != 0);
                send_gap = send_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (sample_queue.size() != 0 &&
                             !(sent_count == PAUSE_AT && expected_points.size() != 0)) begin
                    // hold off once until every result is back
                    current_sample = sample_queue.pop_front();
                    s_tdata <= DW_IN'({current_sample.y, current_sample.x});
                    s_tuser <= {current_sample.y_null, current_sample.x_null};
                    s_tlast <= current_sample.last;
                    next_valid = 1'b1;
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // result monitor: checks each transfer against the oldest expected point
    always @(posedge aclk) begin
        point_t want;
        int     nwait;
        if (!aresetn) begin
            ready_wait = 0;
            m_tready <= 1'b0;
        end else begin
            nwait = ready_wait;
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_tuser[0] !== want.point_valid) begin
                        $error("point_valid expected %0b got %0b", want.point_valid, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[SW-1:0] !== want.x) begin
                        $error("x_out expected %0d got %0d",
                               $signed(want.x), $signed(m_tdata[SW-1:0]));
                        errors++;
                    end
                    if (m_tdata[SW+IW-1:SW] !== want.integral) begin
                        $error("integral_out expected %0d got %0d",
                               $signed(want.integral), $signed(m_tdata[SW+IW-1:SW]));
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("end_out expected %0b got %0b", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[1] !== want.too_short) begin
                        $error("too_short expected %0b got %0b", want.too_short, m_tuser[1]);
                        errors++;
                    end
                    if (m_tuser[2] !== want.saturated) begin
                        $error("saturated expected %0b got %0b", want.saturated, m_tuser[2]);
                        errors++;
                    end
                    series_seen += want.last;
                    clean_seen += want.point_valid;
                    clipped_seen += want.saturated;
                    short_seen += want.too_short;
                end
                results_seen++;
                if (results_seen % 130 == 0)
                    recv_idle_on = ($urandom_range(0, 2) != 0);
                // one long hold-off so the block backs up into its input
                if (results_seen == HOLD_AT)
                    nwait = HOLD_CYCLES;
                else
                    nwait = recv_idle_on ? $urandom_range(0, 4) : 0;
            end else if (nwait != 0) begin
                nwait--;
            end
            ready_wait = nwait;
            m_tready <= (nwait == 0);
        end
    end

    // run limit
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int            len, mode, xr, k, random_items;
        logic [SW-1:0] xv, yv;
        logic [1:0]    nulls;
        bit            noise;

        // single clean point closes a series
        add_sample('0, '0, 1'b0, 1'b0, 1'b1);
        // series of dropped samples only
        add_sample(S_ONE, S_ONE, 1'b1, 1'b0, 1'b0);
        add_sample(S_ONE, S_ONE, 1'b0, 1'b1, 1'b0);
        add_sample(S_MAX, S_MIN, 1'b1, 1'b1, 1'b1);
        // zero crossing, backward step in x, end on a dropped sample
        add_sample('0, S_ONE, 1'b0, 1'b0, 1'b0);
        add_sample(S_ONE, -S_ONE, 1'b0, 1'b0, 1'b0);
        add_sample(3 * S_ONE, -3 * S_ONE, 1'b0, 1'b0, 1'b0);
        add_sample('0, 4 * S_ONE, 1'b0, 1'b0, 1'b0);
        add_sample(S_ONE, S_ONE, 1'b1, 1'b0, 1'b1);
        // positive area close to the top of the range, then negative steps back
        add_sample(S_MIN, S_MAX, 1'b0, 1'b0, 1'b0);
        add_sample(S_MAX, S_MAX, 1'b0, 1'b0, 1'b0);
        add_sample(S_MIN, S_MIN, 1'b0, 1'b0, 1'b0);
        add_sample(S_MAX, S_MIN, 1'b0, 1'b0, 1'b1);
        // negative clip
        add_sample(S_MAX, S_MIN, 1'b0, 1'b0, 1'b0);
        add_sample(S_MIN, S_MIN, 1'b0, 1'b0, 1'b0);
        add_sample(S_MAX, S_MIN, 1'b0, 1'b0, 1'b0);
        add_sample('1, '1, 1'b0, 1'b0, 1'b1);
        // one clean point then a dropped end
        add_sample(5, 7, 1'b0, 1'b0, 1'b0);
        add_sample(9, 9, 1'b0, 1'b1, 1'b1);
        // zero width step and halving of odd areas
        add_sample(S_ONE, S_ONE, 1'b0, 1'b0, 1'b0);
        add_sample(S_ONE, S_MAX, 1'b0, 1'b0, 1'b0);
        add_sample(S_ONE + 1, -2, 1'b0, 1'b0, 1'b0);
        add_sample(S_ONE + 2, '1, 1'b0, 1'b0, 1'b1);

        // random series, mostly clean, some dropped samples
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            len = $urandom_range(1, 16);
            mode = $urandom_range(0, 9);
            xr = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            for (k = 0; k < len; k++) begin
                noise = ($urandom_range(0, 9) == 0);
                if (mode < 2) begin
                    xv = $urandom;
                    yv = $urandom;
                end else if (mode == 2) begin
                    xv = pick_extreme();
                    yv = pick_extreme();
                end else begin
                    if ($urandom_range(0, 7) == 0)
                        xr = xr - int'($urandom_range(0, 1 << 18));
                    else
                        xr = xr + int'($urandom_range(0, 1 << 18));
                    xv = xr;
                    yv = int'($urandom_range(0, 1 << 22)) - (1 << 21);
                end
                nulls = noise ? 2'($urandom_range(1, 3)) : 2'b00;
                add_sample(xv, yv, nulls[0], nulls[1], k == len - 1);
                random_items++;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for all samples to go in and all results to come back
        @(negedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_points.size() != 0) begin
            $error("%0d expected results never arrived", expected_points.size());
            errors++;
        end

        $display("covered %0d samples in %0d series: %0d clean points, %0d short series",
                 results_seen, series_seen, clean_seen, short_seen);
        $display("%0d results flagged as clipped, %0d mismatches", clipped_seen, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
